### src/pfc_pkg.sv
// Shared types, constants and field helpers for the primitive frustum culler.
package pfc_pkg;

   localparam int COORD_BITS = 24;
   localparam int N_W        = 13;
   localparam int D_W        = 25;
   localparam int PT_W       = COORD_BITS + 1;
   localparam int PROD_W     = PT_W + N_W + 1;
   localparam int ACC_W      = PROD_W + 3;
   localparam int FRAC_SHIFT = 12;
   localparam int Q_W        = ACC_W - FRAC_SHIFT;
   localparam int NUM_PLANE_REGS = 6;

   localparam logic [2:0] REG_LAYER_MASK = 3'd6;
   localparam logic [2:0] REG_DEPTH_ROW  = 3'd7;

   localparam logic [1:0] OUT_VISIBLE     = 2'd0;
   localparam logic [1:0] OUT_INVALID_BOX = 2'd1;
   localparam logic [1:0] OUT_LAYER_REJ   = 2'd2;
   localparam logic [1:0] OUT_FRUSTUM_REJ = 2'd3;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] min_x;
      logic signed [COORD_BITS-1:0] min_y;
      logic signed [COORD_BITS-1:0] min_z;
      logic signed [COORD_BITS-1:0] max_x;
      logic signed [COORD_BITS-1:0] max_y;
      logic signed [COORD_BITS-1:0] max_z;
      logic signed [COORD_BITS-1:0] origin_x;
      logic signed [COORD_BITS-1:0] origin_y;
      logic signed [COORD_BITS-1:0] origin_z;
      logic [31:0]                  layer_bits;
      logic                         culling_disabled;
      logic                         first_of_list;
   } req_type;

   typedef struct packed {
      logic [31:0]        primitive_index;
      logic               visible;
      logic [1:0]         outcome;
      logic signed [31:0] view_depth;
   } rsp_type;

   typedef struct packed {
      logic [31:0]            idx;
      logic signed [PT_W-1:0] pt_x;
      logic signed [PT_W-1:0] pt_y;
      logic signed [PT_W-1:0] pt_z;
      logic signed [PT_W-1:0] ext_x;
      logic signed [PT_W-1:0] ext_y;
      logic signed [PT_W-1:0] ext_z;
      logic                   test_en;
      logic                   reject;
      logic                   layer_rej;
      logic                   box_ok;
   } cell_item_type;

   function automatic logic signed [N_W-1:0] plane_n(input logic [63:0] p, input int k);
      return p[N_W*k +: N_W];
   endfunction

   function automatic logic signed [D_W-1:0] plane_d(input logic [63:0] p);
      return p[63:39];
   endfunction

endpackage

### src/primitive_frustum_culler_unit.sv
// Top level of the primitive frustum culler: registers, input stage, plane cells, depth.
//
// One primitive enters on the req_ channel (req_valid, req_stall, req_data) and one
// result leaves on the rsp_ channel (rsp_valid, rsp_stall, rsp_data) for every
// transaction, in order. A transaction is taken on a clock edge with valid high and
// stall low.
// The pipeline is one input stage, two stages per plane cell (products, then sum and
// sign) for min(NUM_PLANES,6) cells, one depth-product stage and the output register.
// Throughput is one transaction per cycle unless a stalled result holds the pipeline;
// the plane cells form a chain that every item walks through, one cell stage per cycle.
// The whole pipeline moves together: while a result sits in the output register and
// rsp_stall is high, every stage holds and req_stall is raised. Bubbles advance with
// the pipeline.
// Reset clears all stage valid flags, the primitive counter and the registers
// (planes and depth row to zero, layer mask to all ones). Registers are written
// through the APB port at byte address 8*i and are expected to change only while
// the pipeline is empty.
module primitive_frustum_culler_unit #(
   parameter int NUM_PLANES = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pfc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pfc_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [5:0]       paddr,
   input  logic [63:0]      pwdata,
   output logic [63:0]      prdata,
   output logic             pready
);
   import pfc_pkg::*;

   localparam int NCELL = (NUM_PLANES < NUM_PLANE_REGS) ? NUM_PLANES : NUM_PLANE_REGS;

   logic [63:0]   plane_ff [NUM_PLANE_REGS];
   logic [31:0]   layer_mask_ff;
   logic [63:0]   depth_row_ff;
   logic [2:0]    widx;
   logic          wr_en;
   logic          adv;
   logic          accept;
   logic [31:0]   cnt_ff;
   logic [31:0]   idx;
   logic          s0_valid_ff;
   cell_item_type s0_in;
   cell_item_type s0_ff;
   logic signed [COORD_BITS-1:0] lo [3];
   logic signed [COORD_BITS-1:0] hi [3];
   logic signed [COORD_BITS-1:0] org [3];
   logic signed [PT_W-1:0]       c2 [3];
   logic signed [PT_W-1:0]       e2 [3];
   logic signed [PT_W-1:0]       pt [3];
   logic          box_ok;
   logic          cv [NCELL+1];
   cell_item_type citem [NCELL+1];

   // register port
   assign pready = 1'b1;
   assign widx   = paddr[5:3];
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PLANE_REGS; i++) plane_ff[i] <= 64'd0;
         layer_mask_ff <= 32'hFFFF_FFFF;
         depth_row_ff  <= 64'd0;
      end else if (wr_en) begin
         unique case (widx)
            REG_LAYER_MASK: layer_mask_ff <= pwdata[31:0];
            REG_DEPTH_ROW:  depth_row_ff  <= pwdata;
            default:        plane_ff[widx] <= pwdata;
         endcase
      end
   end

   always_comb begin
      unique case (widx)
         REG_LAYER_MASK: prdata = {32'd0, layer_mask_ff};
         REG_DEPTH_ROW:  prdata = depth_row_ff;
         default:        prdata = plane_ff[widx];
      endcase
   end

   // flow control
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;
   assign accept    = req_valid && adv;

   // input stage
   assign lo[0]  = req_data.min_x;
   assign lo[1]  = req_data.min_y;
   assign lo[2]  = req_data.min_z;
   assign hi[0]  = req_data.max_x;
   assign hi[1]  = req_data.max_y;
   assign hi[2]  = req_data.max_z;
   assign org[0] = req_data.origin_x;
   assign org[1] = req_data.origin_y;
   assign org[2] = req_data.origin_z;

   always_comb begin
      box_ok = 1'b1;
      for (int i = 0; i < 3; i++) begin
         c2[i] = PT_W'(lo[i]) + PT_W'(hi[i]);
         e2[i] = PT_W'(hi[i]) - PT_W'(lo[i]);
         if (lo[i] > hi[i]) box_ok = 1'b0;
      end
      for (int i = 0; i < 3; i++) begin
         pt[i] = box_ok ? c2[i] : {org[i], 1'b0};
      end
      idx             = req_data.first_of_list ? 32'd0 : cnt_ff;
      s0_in.idx       = idx;
      s0_in.pt_x      = pt[0];
      s0_in.pt_y      = pt[1];
      s0_in.pt_z      = pt[2];
      s0_in.ext_x     = e2[0];
      s0_in.ext_y     = e2[1];
      s0_in.ext_z     = e2[2];
      s0_in.layer_rej = (req_data.layer_bits & layer_mask_ff) == 32'd0;
      s0_in.box_ok    = box_ok;
      s0_in.test_en   = !s0_in.layer_rej && box_ok && !req_data.culling_disabled;
      s0_in.reject    = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= 32'd0;
         s0_valid_ff <= 1'b0;
      end else begin
         if (adv) s0_valid_ff <= req_valid;
         if (accept) cnt_ff <= idx + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) s0_ff <= s0_in;
   end

   // plane cell chain
   assign cv[0]    = s0_valid_ff;
   assign citem[0] = s0_ff;

   for (genvar g = 0; g < NCELL; g++) begin : g_cell
      pfc_plane_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (cv[g]),
         .in_item   (citem[g]),
         .plane     (plane_ff[g]),
         .out_valid (cv[g+1]),
         .out_item  (citem[g+1])
      );
   end

   pfc_depth_unit u_depth (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (cv[NCELL]),
      .in_item   (citem[NCELL]),
      .depth_row (depth_row_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a blocked result");
   a_list_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.first_of_list) |=> (cnt_ff == 32'd1))
      else $error("counter not restarted by first_of_list");
   a_hidden_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.visible) |-> (rsp_data.view_depth == 32'sd0))
      else $error("culled primitive carries a depth");
   a_visible_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.visible ==
         (rsp_data.outcome == OUT_VISIBLE || rsp_data.outcome == OUT_INVALID_BOX)))
      else $error("visible flag disagrees with outcome");
`endif

endmodule

### src/pfc_plane_cell.sv
// One plane-test cell: products in the first stage, sum and sign check in the second.
module pfc_plane_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  pfc_pkg::cell_item_type in_item,
   input  logic [63:0]            plane,
   output logic                   out_valid,
   output pfc_pkg::cell_item_type out_item
);
   import pfc_pkg::*;

   logic signed [N_W-1:0]    n [3];
   logic signed [N_W:0]      n_mag [3];
   logic signed [PT_W-1:0]   pt [3];
   logic signed [PT_W-1:0]   ext [3];
   logic signed [PROD_W-1:0] pc_in [3];
   logic signed [PROD_W-1:0] pe_in [3];
   logic signed [PROD_W-1:0] pc_ff [3];
   logic signed [PROD_W-1:0] pe_ff [3];
   logic signed [ACC_W-1:0]  sum;
   cell_item_type            a_item_ff;
   cell_item_type            b_item_in;
   cell_item_type            b_item_ff;
   logic                     a_valid_ff;
   logic                     b_valid_ff;

   assign pt[0]  = in_item.pt_x;
   assign pt[1]  = in_item.pt_y;
   assign pt[2]  = in_item.pt_z;
   assign ext[0] = in_item.ext_x;
   assign ext[1] = in_item.ext_y;
   assign ext[2] = in_item.ext_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n[i]     = plane_n(plane, i);
         n_mag[i] = n[i][N_W-1] ? -{n[i][N_W-1], n[i]} : {n[i][N_W-1], n[i]};
         pc_in[i] = PROD_W'(n[i]) * PROD_W'(pt[i]);
         pe_in[i] = PROD_W'(n_mag[i]) * PROD_W'(ext[i]);
      end
   end

   always_comb begin
      sum = ACC_W'(plane_d(plane)) <<< FRAC_SHIFT;
      for (int i = 0; i < 3; i++) begin
         sum = sum + ACC_W'(pc_ff[i]) + ACC_W'(pe_ff[i]);
      end
      b_item_in        = a_item_ff;
      b_item_in.reject = a_item_ff.reject | (a_item_ff.test_en & sum[ACC_W-1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_item_ff <= in_item;
         pc_ff     <= pc_in;
         pe_ff     <= pe_in;
         b_item_ff <= b_item_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;

endmodule

### src/pfc_depth_unit.sv
// Depth dot product, rounding and result formatting into the output register.
module pfc_depth_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  pfc_pkg::cell_item_type in_item,
   input  logic [63:0]            depth_row,
   output logic                   rsp_valid,
   output pfc_pkg::rsp_type       rsp_data
);
   import pfc_pkg::*;

   logic signed [PT_W-1:0]   pt [3];
   logic signed [PROD_W-1:0] rp_in [3];
   logic signed [PROD_W-1:0] rp_ff [3];
   logic signed [ACC_W-1:0]  acc;
   logic signed [Q_W-1:0]    q;
   cell_item_type            item_ff;
   logic                     v1_ff;
   rsp_type                  rsp_in;
   rsp_type                  rsp_ff;
   logic                     rsp_valid_ff;

   assign pt[0] = in_item.pt_x;
   assign pt[1] = in_item.pt_y;
   assign pt[2] = in_item.pt_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rp_in[i] = PROD_W'(plane_n(depth_row, i)) * PROD_W'(pt[i]);
      end
   end

   always_comb begin
      acc = (ACC_W'(plane_d(depth_row)) <<< FRAC_SHIFT) + ACC_W'(2048);
      for (int i = 0; i < 3; i++) begin
         acc = acc + ACC_W'(rp_ff[i]);
      end
      q = Q_W'(acc >>> FRAC_SHIFT);
      rsp_in.primitive_index = item_ff.idx;
      if (item_ff.layer_rej) begin
         rsp_in.outcome = OUT_LAYER_REJ;
      end else if (item_ff.reject) begin
         rsp_in.outcome = OUT_FRUSTUM_REJ;
      end else if (item_ff.box_ok) begin
         rsp_in.outcome = OUT_VISIBLE;
      end else begin
         rsp_in.outcome = OUT_INVALID_BOX;
      end
      rsp_in.visible    = !item_ff.layer_rej && !item_ff.reject;
      // depth range stays inside 32 bits for these widths, so no clamp
      rsp_in.view_depth = rsp_in.visible ? 32'(q) : 32'sd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= in_valid;
         rsp_valid_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rp_ff   <= rp_in;
         item_ff <= in_item;
         rsp_ff  <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
